FILE: hdl/lrc_tep_pkg.sv
// ============================================================================
// lrc_tep_pkg
// Shared types, widths and character codes of the lyric timestamp parser.
// ============================================================================
package lrc_tep_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int NUMBER_WIDTH = 16;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = {NUMBER_WIDTH{1'b1}};

    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CH_LBRK   = 8'h5B;  // '['
    localparam logic [7:0] CH_RBRK   = 8'h5D;  // ']'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] NUM_MIN  = 2'd0;
    localparam logic [1:0] NUM_SEC  = 2'd1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } lrc_tep_in_t;

    typedef struct packed {
        logic        event_kind;
        logic [15:0] text_offset;
        logic [27:0] frame_count;
    } lrc_tep_out_t;

    // Time-tag parse state, cleared whenever a tag opens.
    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] minutes;
        logic [NUMBER_WIDTH-1:0] seconds;
        logic [NUMBER_WIDTH-1:0] hundredths;
        logic [1:0]              index;
        logic                    has_digit;
        logic                    stopped;
        logic                    first_seen;
        logic                    is_timestamp;
    } lrc_tep_tag_t;

endpackage

FILE: hdl/lrc_timestamp_event_parser.sv
// ============================================================================
// lrc_timestamp_event_parser
// Lyric file byte parser: tracks text length and emits timing transactions.
// ============================================================================
// Path: an accepted byte passes the input register, then the state update and
//   result register, before any result it makes shows on rsp.
// Throughput: one byte per cycle while rsp is not stalled, set by the state
//   update loop; the result register lets a new byte enter while a result waits.
// Reset: rst_n clears all parse state to text mode and drops both registers.
module lrc_timestamp_event_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lrc_tep_pkg::lrc_tep_in_t  req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output lrc_tep_pkg::lrc_tep_out_t rsp
);
    import lrc_tep_pkg::*;

    localparam logic [1:0] MODE_TEXT    = 2'd0;
    localparam logic [1:0] MODE_ANGLE   = 2'd1;
    localparam logic [1:0] MODE_BRACKET = 2'd2;

    localparam int OW2 = OFFSET_WIDTH + 2;

    // ------------------------------------------------------------------
    // Input register and pipeline control
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    lrc_tep_in_t in_data_reg;
    logic        out_valid_reg;
    lrc_tep_out_t out_data_reg;

    logic advance;
    logic accept;
    logic fire;

    // Advance whenever the result register is empty or being drained.
    assign advance   = !out_valid_reg || !rsp_stall;
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign fire      = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= req;
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic [1:0]              mode_reg,        mode_next;
    logic                    started_reg,     started_next;
    logic                    once_reg,        once_next;
    logic [OFFSET_WIDTH-1:0] committed_reg,   committed_next;
    logic [OFFSET_WIDTH-1:0] line_len_reg,    line_len_next;
    lrc_tep_tag_t            tag_reg,         tag_next;
    lrc_tep_tag_t            tag_stepped;

    logic [7:0] ch;
    assign ch = in_data_reg.in_byte;

    lrc_tep_tag_step u_tag_step (
        .tag      (tag_reg),
        .ch       (ch),
        .tag_next (tag_stepped)
    );

    // Saturating offset sums.
    logic [OW2-1:0]          commit_sum;
    logic [OW2-1:0]          offset_sum;
    logic [OW2-1:0]          line_inc;
    logic [OFFSET_WIDTH-1:0] commit_sat;
    logic [OFFSET_WIDTH-1:0] offset_sat;
    logic [OFFSET_WIDTH-1:0] line_inc_sat;

    assign commit_sum   = OW2'(committed_reg) + OW2'(line_len_reg) + OW2'(once_reg);
    assign offset_sum   = OW2'(committed_reg) + OW2'(line_len_reg);
    assign line_inc     = OW2'(line_len_reg) + OW2'(1);
    assign commit_sat   = (commit_sum > OW2'(OFF_MAX)) ? OFF_MAX
                                                       : commit_sum[OFFSET_WIDTH-1:0];
    assign offset_sat   = (offset_sum > OW2'(OFF_MAX)) ? OFF_MAX
                                                       : offset_sum[OFFSET_WIDTH-1:0];
    assign line_inc_sat = (line_inc > OW2'(OFF_MAX)) ? OFF_MAX
                                                     : line_inc[OFFSET_WIDTH-1:0];

    // Frame count = (min*6000 + sec*100 + hundredths) / 2; products in parallel.
    logic [31:0] total_hund;
    logic [OFFSET_WIDTH+15:0] offset_ext;

    assign total_hund = 32'(tag_reg.minutes) * 32'd6000 +
                        32'(tag_reg.seconds) * 32'd100 +
                        32'(tag_reg.hundredths);
    assign offset_ext = {16'd0, offset_sat};

    logic         emit;
    lrc_tep_out_t result;

    always_comb
    begin
        mode_next      = mode_reg;
        started_next   = started_reg;
        once_next      = once_reg;
        committed_next = committed_reg;
        line_len_next  = line_len_reg;
        tag_next       = tag_reg;
        emit           = 1'b0;
        result.event_kind  = 1'b0;
        result.text_offset = offset_ext[15:0];
        result.frame_count = total_hund[28:1];

        if (in_data_reg.end_of_input)
        begin
            // End marker: emit it and return to the reset state.
            emit               = 1'b1;
            result.event_kind  = 1'b1;
            result.text_offset = 16'd0;
            result.frame_count = 28'd0;
            mode_next          = MODE_TEXT;
            started_next       = 1'b0;
            once_next          = 1'b0;
            committed_next     = '0;
            line_len_next      = '0;
            tag_next           = '0;
        end
        else if (mode_reg == MODE_ANGLE || mode_reg == MODE_BRACKET)
        begin
            if (ch != ((mode_reg == MODE_ANGLE) ? CH_GT : CH_RBRK))
            begin
                tag_next = tag_stepped;
            end
            else
            begin
                // Close the tag; metadata brackets produce nothing.
                mode_next = MODE_TEXT;
                emit      = (mode_reg == MODE_ANGLE) || tag_reg.is_timestamp;
            end
        end
        else if (ch == CH_LT)
        begin
            mode_next = MODE_ANGLE;
            tag_next  = '0;
        end
        else if (ch == CH_LBRK)
        begin
            mode_next = MODE_BRACKET;
            tag_next  = '0;
        end
        else if (ch == CH_LF)
        begin
            // Commit the line, with a separator after the first one.
            if (started_reg)
            begin
                committed_next = commit_sat;
                once_next      = 1'b1;
            end
            line_len_next = '0;
        end
        else
        begin
            // Skip leading blanks; count everything once text has started.
            if (ch != CH_SPACE && ch != CH_TAB)
            begin
                started_next  = 1'b1;
                line_len_next = line_inc_sat;
            end
            else if (started_reg)
            begin
                line_len_next = line_inc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TEXT;
            started_reg   <= 1'b0;
            once_reg      <= 1'b0;
            committed_reg <= '0;
            line_len_reg  <= '0;
            tag_reg       <= '0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            started_reg   <= started_next;
            once_reg      <= once_next;
            committed_reg <= committed_next;
            line_len_reg  <= line_len_next;
            tag_reg       <= tag_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold while stalled, load on an emitting transaction
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_data_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

FILE: hdl/lrc_tep_tag_step.sv
// ============================================================================
// lrc_tep_tag_step
// Next tag parse state for one character inside a tag (min:sec.hundredths).
// ============================================================================
module lrc_tep_tag_step (
    input  lrc_tep_pkg::lrc_tep_tag_t tag,
    input  logic [7:0]                 ch,
    output lrc_tep_pkg::lrc_tep_tag_t tag_next
);
    import lrc_tep_pkg::*;

    localparam int NW4 = NUMBER_WIDTH + 4;

    logic                    is_digit;
    logic                    is_space;
    logic [NUMBER_WIDTH-1:0] sel_value;
    logic [NW4-1:0]          product;
    logic [NUMBER_WIDTH-1:0] new_value;
    logic [7:0]              digit;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                      (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
    assign digit    = ch - CH_ZERO;

    always_comb
    begin
        case (tag.index)
            NUM_MIN: sel_value = tag.minutes;
            NUM_SEC: sel_value = tag.seconds;
            default: sel_value = tag.hundredths;
        endcase
    end

    // Accumulate one decimal digit, saturate at full scale.
    assign product   = NW4'(sel_value) * NW4'(10) + NW4'(digit[3:0]);
    assign new_value = (product > NW4'(NUM_MAX)) ? NUM_MAX : product[NUMBER_WIDTH-1:0];

    always_comb
    begin
        tag_next = tag;
        if (!tag.first_seen)
        begin
            tag_next.first_seen   = 1'b1;
            tag_next.is_timestamp = is_digit;
        end
        if (!tag.stopped)
        begin
            if (is_digit)
            begin
                tag_next.has_digit = 1'b1;
                case (tag.index)
                    NUM_MIN: tag_next.minutes    = new_value;
                    NUM_SEC: tag_next.seconds    = new_value;
                    default: tag_next.hundredths = new_value;
                endcase
            end
            else if (!tag.has_digit)
            begin
                if (!is_space)
                    tag_next.stopped = 1'b1;
            end
            else if ((tag.index == NUM_MIN && ch == CH_COLON) ||
                     (tag.index == NUM_SEC && ch == CH_DOT))
            begin
                tag_next.index     = tag.index + 2'd1;
                tag_next.has_digit = 1'b0;
            end
            else
            begin
                tag_next.stopped = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/lrc_tep_checker.sv
// ============================================================================
// lrc_tep_checker
// Port-level checks of the lyric timestamp parser, bound to the top level.
// ============================================================================
module lrc_tep_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input lrc_tep_pkg::lrc_tep_in_t  req,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input lrc_tep_pkg::lrc_tep_out_t rsp
);
    import lrc_tep_pkg::*;

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // End marker carries zero offset and zero frame count.
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.event_kind |-> rsp.text_offset == 16'd0 &&
                                        rsp.frame_count == 28'd0)
        else $error("end marker with nonzero payload");

    // Unless rsp stalls, an accepted end item emerges as an end marker.
    a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.end_of_input) ##1 !rsp_stall
            |=> rsp_valid && rsp.event_kind)
        else $error("end marker missing");

    // Frame count never exceeds the saturated maximum.
    a_frame_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.frame_count <= 28'd199914517)
        else $error("frame count out of range");

endmodule

bind lrc_timestamp_event_parser lrc_tep_checker u_lrc_tep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the lyric timestamp parser. A short directed table
// runs first, then generated lyric files under changing idle and stall rates.
// Every output transaction is checked against an in-bench parser model or a fixed table row.
// ============================================================================
module tb;
    import lrc_tep_pkg::*;

    localparam int     CLK_HALF_NS  = 5;
    localparam int     RESET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 16;       // leave plenty of slack
    localparam int     RANDOM_ITEMS = 900;
    localparam int     MAX_PRINTS   = 40;
    // Generous limit on the whole run.
    localparam longint TIMEOUT_NS   = 500_000;
    localparam int     DIR_ROWS     = 30;

    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_ANGLE   = 2'd1,
        MODE_BRACKET = 2'd2
    } parse_mode_e;

    // One row of the directed table. When 'fixed' is set the expected
    // transaction is the one typed in the row, not the model's.
    typedef struct packed {
        logic [7:0]   c;
        logic         eoi;
        logic         fixed;
        lrc_tep_out_t ev;
    } dir_row_t;

    localparam lrc_tep_out_t END_EV  = '{event_kind: 1'b1, text_offset: 16'd0,
                                         frame_count: 28'd0};
    localparam lrc_tep_out_t ZERO_EV = '{event_kind: 1'b0, text_offset: 16'd0,
                                         frame_count: 28'd0};

    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        '{8'h00,    1'b1, 1'b1, END_EV},   // end marker straight out of reset
        '{CH_LT,    1'b0, 1'b0, ZERO_EV},  // empty angle tag: offset 0, time 0
        '{CH_GT,    1'b0, 1'b1, ZERO_EV},
        '{CH_SPACE, 1'b0, 1'b0, ZERO_EV},  // leading blanks are skipped
        '{CH_TAB,   1'b0, 1'b0, ZERO_EV},
        '{8'h41,    1'b0, 1'b0, ZERO_EV},  // 'A' starts the text
        '{CH_LF,    1'b0, 1'b0, ZERO_EV},  // first committed line, no separator
        '{8'hFF,    1'b0, 1'b0, ZERO_EV},  // top byte counts as text
        '{CH_LBRK,  1'b0, 1'b0, ZERO_EV},  // [1:2.3] time tag
        '{8'h31,    1'b0, 1'b0, ZERO_EV},
        '{CH_COLON, 1'b0, 1'b0, ZERO_EV},
        '{8'h32,    1'b0, 1'b0, ZERO_EV},
        '{CH_DOT,   1'b0, 1'b0, ZERO_EV},
        '{8'h33,    1'b0, 1'b0, ZERO_EV},
        '{CH_RBRK,  1'b0, 1'b0, ZERO_EV},
        '{CH_LBRK,  1'b0, 1'b0, ZERO_EV},  // [a] metadata: no transaction
        '{8'h61,    1'b0, 1'b0, ZERO_EV},
        '{CH_RBRK,  1'b0, 1'b0, ZERO_EV},
        '{CH_LT,    1'b0, 1'b0, ZERO_EV},  // <-5> sign stops the number
        '{8'h2D,    1'b0, 1'b0, ZERO_EV},
        '{8'h35,    1'b0, 1'b0, ZERO_EV},
        '{CH_GT,    1'b0, 1'b0, ZERO_EV},
        '{CH_LT,    1'b0, 1'b0, ZERO_EV},  // <99999> minutes saturate
        '{8'h39,    1'b0, 1'b0, ZERO_EV},
        '{8'h39,    1'b0, 1'b0, ZERO_EV},
        '{8'h39,    1'b0, 1'b0, ZERO_EV},
        '{8'h39,    1'b0, 1'b0, ZERO_EV},
        '{8'h39,    1'b0, 1'b0, ZERO_EV},
        '{CH_GT,    1'b0, 1'b0, ZERO_EV},
        '{8'hA5,    1'b1, 1'b1, END_EV}    // byte is ignored on end of input
    };

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_stall;
    lrc_tep_in_t  req       = '0;
    logic         rsp_valid;
    logic         rsp_stall = 1'b0;
    lrc_tep_out_t rsp;

    int unsigned  idle_pct;
    int unsigned  stall_pct;
    int           mismatch_count = 0;

    lrc_tep_out_t timing_events_due [$];
    lrc_tep_in_t  lyric_q [$];

    // Parser model state
    parse_mode_e             mdl_mode;
    bit                      mdl_started;
    bit                      mdl_committed_once;
    logic [OFFSET_WIDTH-1:0] mdl_committed;
    logic [OFFSET_WIDTH-1:0] mdl_line;
    lrc_tep_tag_t            mdl_tag;

    lrc_timestamp_event_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
               c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    // Saturating add at the offset width
    function automatic logic [OFFSET_WIDTH-1:0] sat_add(input logic [OFFSET_WIDTH-1:0] a,
                                                        input logic [OFFSET_WIDTH-1:0] b);
        logic [OFFSET_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFFSET_WIDTH] ? OFF_MAX : s[OFFSET_WIDTH-1:0];
    endfunction

    // Shift one decimal digit into a number, holding at the number maximum
    function automatic logic [NUMBER_WIDTH-1:0] add_digit(input logic [NUMBER_WIDTH-1:0] v,
                                                          input logic [7:0] c);
        logic [31:0] n;
        n = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
        return (n > 32'(NUM_MAX)) ? NUM_MAX : n[NUMBER_WIDTH-1:0];
    endfunction

    function automatic void open_tag(input parse_mode_e m);
        mdl_mode = m;
        mdl_tag  = '0;
    endfunction

    function automatic void reset_model();
        open_tag(MODE_TEXT);
        mdl_started        = 1'b0;
        mdl_committed_once = 1'b0;
        mdl_committed      = '0;
        mdl_line           = '0;
    endfunction

    // One character inside an open tag: walk the min:sec.hundredths syntax
    function automatic void feed_tag_char(input logic [7:0] c);
        if (!mdl_tag.first_seen)
        begin
            mdl_tag.first_seen   = 1'b1;
            mdl_tag.is_timestamp = is_digit(c);
        end
        if (!mdl_tag.stopped)
        begin
            if (is_digit(c))
            begin
                case (mdl_tag.index)
                    NUM_MIN: mdl_tag.minutes    = add_digit(mdl_tag.minutes, c);
                    NUM_SEC: mdl_tag.seconds    = add_digit(mdl_tag.seconds, c);
                    default: mdl_tag.hundredths = add_digit(mdl_tag.hundredths, c);
                endcase
                mdl_tag.has_digit = 1'b1;
            end
            else if (!mdl_tag.has_digit)
            begin
                // skip blanks before a number, anything else ends the parse
                if (!is_blank(c))
                    mdl_tag.stopped = 1'b1;
            end
            else if ((mdl_tag.index == NUM_MIN && c == CH_COLON) ||
                     (mdl_tag.index == NUM_SEC && c == CH_DOT))
            begin
                mdl_tag.index     = mdl_tag.index + 2'd1;
                mdl_tag.has_digit = 1'b0;
            end
            else
            begin
                mdl_tag.stopped = 1'b1;
            end
        end
    endfunction

    // Advance the model by one accepted byte; report the transaction it causes
    task automatic predict_timing_event(input lrc_tep_in_t item, output bit emit,
                                        output lrc_tep_out_t ev);
        logic [7:0]      c;
        logic [7:0]      close_ch;
        longint unsigned mins;
        longint unsigned secs;
        longint unsigned hunds;
        longint unsigned ms10;
        c    = item.in_byte;
        ev   = ZERO_EV;
        emit = 1'b0;
        if (item.end_of_input)
        begin
            ev   = END_EV;
            emit = 1'b1;
            reset_model();
        end
        else if (mdl_mode == MODE_ANGLE || mdl_mode == MODE_BRACKET)
        begin
            close_ch = (mdl_mode == MODE_ANGLE) ? CH_GT : CH_RBRK;
            if (c != close_ch)
            begin
                feed_tag_char(c);
            end
            else
            begin
                // brackets only time the text when the first char was a digit
                emit     = (mdl_mode == MODE_ANGLE) || mdl_tag.is_timestamp;
                mdl_mode = MODE_TEXT;
                if (emit)
                begin
                    mins  = mdl_tag.minutes;
                    secs  = mdl_tag.seconds;
                    hunds = mdl_tag.hundredths;
                    ms10  = ((mins * 60 + secs) * 100 + hunds) * 10;
                    ev.event_kind  = 1'b0;
                    ev.text_offset = 16'(sat_add(mdl_committed, mdl_line));
                    ev.frame_count = 28'(ms10 / 20);
                end
            end
        end
        else if (c == CH_LT)
        begin
            open_tag(MODE_ANGLE);
        end
        else if (c == CH_LBRK)
        begin
            open_tag(MODE_BRACKET);
        end
        else if (c == CH_LF)
        begin
            if (mdl_started)
            begin
                if (mdl_committed_once)
                    mdl_committed = sat_add(mdl_committed, 1);
                mdl_committed      = sat_add(mdl_committed, mdl_line);
                mdl_committed_once = 1'b1;
            end
            mdl_line = '0;
        end
        else
        begin
            if (c != CH_SPACE && c != CH_TAB)
                mdl_started = 1'b1;
            if (mdl_started)
                mdl_line = sat_add(mdl_line, 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Lyric file generator: mostly well-formed lines with random content,
    // plus damaged tags, stray bytes and files cut off in odd places.
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] c);
        lrc_tep_in_t item;
        item.in_byte      = c;
        item.end_of_input = 1'b0;
        lyric_q.push_back(item);
    endfunction

    function automatic void push_eoi();
        lrc_tep_in_t item;
        item.in_byte      = 8'($urandom_range(255));
        item.end_of_input = 1'b1;
        lyric_q.push_back(item);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // Characters that break the number syntax
    function automatic logic [7:0] junk_char();
        case ($urandom_range(3))
            0:       return 8'h2D;   // '-'
            1:       return 8'h2B;   // '+'
            2:       return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255, 128));
        c = 8'($urandom_range(126, 32));
        if (c == CH_LT || c == CH_LBRK)
            c = CH_SPACE;
        return c;
    endfunction

    function automatic void push_number();
        string       digits;
        int unsigned v;
        if ($urandom_range(9) == 0)
            push_byte(blank_char());
        case ($urandom_range(9))
            0:       v = $urandom_range(999999, 65530);  // near or past the number maximum
            1, 2:    v = $urandom_range(999);
            default: v = $urandom_range(99);
        endcase
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            push_byte(digits[i]);
    endfunction

    function automatic void push_time_tag(input logic [7:0] open_ch, input logic [7:0] close_ch,
                                          input bit damage);
        int unsigned flaw;
        flaw = damage ? $urandom_range(15) : 0;
        push_byte(open_ch);
        if (flaw == 4)
            push_byte(junk_char());
        push_number();
        push_byte(flaw == 1 ? junk_char() : CH_COLON);
        push_number();
        if (flaw != 5)
        begin
            push_byte(flaw == 2 ? junk_char() : CH_DOT);
            push_number();
        end
        if (flaw == 3)
        begin
            push_byte(junk_char());
            push_number();
        end
        push_byte(close_ch);
    endfunction

    function automatic void push_meta_tag();
        push_byte(CH_LBRK);
        repeat ($urandom_range(3, 1))
            push_byte(8'($urandom_range(122, 97)));       // 'a'..'z'
        push_byte(CH_COLON);
        repeat ($urandom_range(6))
            push_byte($urandom_range(4) ? 8'($urandom_range(122, 97)) : CH_SPACE);
        push_byte(CH_RBRK);
    endfunction

    function automatic void gen_line();
        int          n_chars;
        int unsigned pick;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1))
                push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(2))
            push_time_tag(CH_LBRK, CH_RBRK, 1'b1);
        if ($urandom_range(9) == 0)
            push_meta_tag();
        n_chars = $urandom_range(12);
        for (int i = 0; i < n_chars; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                push_byte(8'($urandom_range(255)));        // stray byte
            else if (pick < 16)
                push_time_tag(CH_LT, CH_GT, 1'b1);         // word timing
            else
                push_byte(text_char());
        end
        if ($urandom_range(19) != 0)
            push_byte(CH_LF);
    endfunction

    function automatic void gen_file();
        repeat ($urandom_range(6, 1))
            gen_line();
        case ($urandom_range(9))
            0:
            begin
                // file ends inside an open tag
                push_byte(CH_LT);
                push_number();
                push_eoi();
            end
            1, 2: ;     // no end marker: the next file runs on
            default: push_eoi();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side: drive one byte, hold it while stalled, then update the
    // model and queue the expected transaction.
    // ------------------------------------------------------------------------
    task automatic send_byte(input lrc_tep_in_t item, input bit fixed,
                             input lrc_tep_out_t fixed_ev);
        bit           emit;
        lrc_tep_out_t ev;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_timing_event(item, emit, ev);
        if (fixed)
            timing_events_due.push_back(fixed_ev);
        else if (emit)
            timing_events_due.push_back(ev);
    endtask

    task automatic flush_lyric_q();
        while (lyric_q.size() != 0)
            send_byte(lyric_q.pop_front(), 1'b0, ZERO_EV);
    endtask

    task automatic run_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            gen_file();
            sent += lyric_q.size();
            flush_lyric_q();
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall, check every accepted transaction in order
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_timing_event(input lrc_tep_out_t got);
        lrc_tep_out_t want;
        if (timing_events_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction kind=%0d offset=%0d frames=%0d",
                                      got.event_kind, got.text_offset, got.frame_count));
        end
        else
        begin
            want = timing_events_due.pop_front();
            if (got.event_kind !== want.event_kind)
                report_mismatch($sformatf("event_kind %0d, want %0d",
                                          got.event_kind, want.event_kind));
            if (got.text_offset !== want.text_offset)
                report_mismatch($sformatf("text_offset %0d, want %0d",
                                          got.text_offset, want.text_offset));
            if (got.frame_count !== want.frame_count)
                report_mismatch($sformatf("frame_count %0d, want %0d",
                                          got.frame_count, want.frame_count));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid === 1'b1 && !rsp_stall)
                check_timing_event(rsp);
            else if (rsp_valid !== 1'b0 && rsp_valid !== 1'b1)
                report_mismatch("rsp_valid unknown");
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed table, three random phases, drain
    // ------------------------------------------------------------------------
    initial
    begin
        lrc_tep_in_t item;
        reset_model();
        idle_pct  = 6;
        stall_pct = 64;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TBL[i])
        begin
            item.in_byte      = DIR_TBL[i].c;
            item.end_of_input = DIR_TBL[i].eoi;
            send_byte(item, DIR_TBL[i].fixed, DIR_TBL[i].ev);
        end

        // Sender mostly busy, receiver stalls a lot
        run_random(RANDOM_ITEMS / 3);

        // Swap: sender sparse, receiver nearly always ready
        idle_pct  = 64;
        stall_pct = 6;
        run_random(RANDOM_ITEMS / 3);

        // Back to back on both sides
        idle_pct  = 0;
        stall_pct = 0;
        run_random(RANDOM_ITEMS / 3);
        req_valid <= 1'b0;

        while (timing_events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("lrc_timestamp_event_parser verification clean");
        else
            $display("lrc_timestamp_event_parser verification failed");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("lrc_timestamp_event_parser verification failed");
        $finish;
    end

endmodule
